[sv/rau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Field widths, operation and status codes, and the sequencer state types
// shared by the rational arithmetic unit and its submodules.
// ----------------------------------------------------------------------------
package rau_pkg;

   // Widths of the channel fields; these do not follow the word size.
   localparam int FIELD_W = 32;
   localparam int DEN_W   = 31;
   localparam int KIND_W  = 3;
   localparam int STAT_W  = 2;

   // Operation codes; codes above normalize behave as normalize.
   localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DIV  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NORM = 3'd4;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_ZDEN = 2'd1,
      STAT_DIVZ = 2'd2,
      STAT_OVF  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SUM,
      ST_GCD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      GP_IDLE,
      GP_COMMON,
      GP_STRIP,
      GP_LOOP
   } gcd_phase_type;

endpackage
`default_nettype wire

[sv/rau_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface rau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [31:0] a_num;
   logic signed [31:0] a_den;
   logic signed [31:0] b_num;
   logic signed [31:0] b_den;

   modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_num;
   logic [30:0]        res_den;
   logic [1:0]         status;

   modport source (output valid, res_num, res_den, status, input ready);
   modport sink   (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

[sv/rau_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rau_mul #(
   parameter int W = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [W-1:0]   op_a,
   input  wire logic [W-1:0]   op_b,
   output logic                done,
   output logic [2*W-1:0]      prod
);
   localparam int PW = 2 * W;
   localparam int CW = $clog2(W + 1);

   logic [PW-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [W-1:0]  mplr_ff, mplr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   // One partial product is added per cycle while the multiplier shifts out.
   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = '0;
         mcand_in = PW'(op_a);
         mplr_in  = op_b;
         cnt_in   = CW'(W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (mplr_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff << 1;
         mplr_in  = mplr_ff >> 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

[sv/rau_gcd.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary GCD engine
// Finds the odd part of the greatest common divisor of two nonzero values,
// one shift or one compare-and-subtract per cycle. It also returns both
// inputs with their common power of two removed.
// ----------------------------------------------------------------------------
module rau_gcd
   import rau_pkg::*;
#(
   parameter int PW = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [PW-1:0] u_init,
   input  wire logic [PW-1:0] v_init,
   output logic               done,
   output logic [PW-1:0]      g_odd,
   output logic [PW-1:0]      u_red,
   output logic [PW-1:0]      v_red
);
   gcd_phase_type phase_ff, phase_in;
   logic [PW-1:0] u_ff, u_in, v_ff, v_in, ur_ff, ur_in, vr_ff, vr_in;
   logic          done_ff, done_in;

   always_ff @(posedge clock) begin
      u_ff  <= u_in;
      v_ff  <= v_in;
      ur_ff <= ur_in;
      vr_ff <= vr_in;
      if (reset) begin
         phase_ff <= GP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // Common halving, stripping u to odd, then the subtract loop.
   always_comb begin
      phase_in = phase_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      ur_in    = ur_ff;
      vr_in    = vr_ff;
      done_in  = 1'b0;
      case (phase_ff)
         GP_IDLE: begin
            if (start) begin
               u_in     = u_init;
               v_in     = v_init;
               phase_in = GP_COMMON;
            end
         end
         GP_COMMON: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
            end else begin
               ur_in    = u_ff;
               vr_in    = v_ff;
               phase_in = GP_STRIP;
            end
         end
         GP_STRIP: begin
            if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else begin
               phase_in = GP_LOOP;
            end
         end
         GP_LOOP: begin
            if (v_ff == '0) begin
               done_in  = 1'b1;
               phase_in = GP_IDLE;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_in = v_ff;
               v_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         default: begin
            phase_in = GP_IDLE;
         end
      endcase
   end

   assign done  = done_ff;
   assign g_odd = u_ff;
   assign u_red = ur_ff;
   assign v_red = vr_ff;
endmodule
`default_nettype wire

[sv/rau_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
   parameter int PW = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [PW-1:0] dividend,
   input  wire logic [PW-1:0] divisor,
   output logic               done,
   output logic [PW-1:0]      quot
);
   localparam int CW = $clog2(PW + 1);

   logic [PW:0]   rem_ff, rem_in, trial;
   logic [PW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in, fits;

   // The dividend shifts out at the top while quotient bits shift in below.
   always_comb begin
      trial   = {rem_ff[PW-1:0], q_ff[PW-1]};
      fits    = trial >= {1'b0, divisor};
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         q_in    = dividend;
         cnt_in  = CW'(PW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, divisor}) : trial;
         q_in   = {q_ff[PW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

[sv/rational_arith_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two signed fractions, or normalizes
// one, and returns the result reduced to lowest terms with a status code.
// ----------------------------------------------------------------------------
// Usage: present an operation and two fractions on req_ch; a transfer
// happens when valid and ready are both high. Exactly one result comes back
// on rsp_ch for each request, in order. Operands are the low WORD_BITS bits
// of each field. One item is worked on at a time; req_ch.ready is high only
// while the sequencer is idle.
// Units: cross products come from one bit-serial multiplier (up to three
// products). The binary GCD engine takes one shift or subtract per cycle
// on 2*WORD_BITS-bit values, and the serial dividers then divide by the
// odd part of the GCD. Error results skip the units, and a zero numerator
// skips the GCD engine and the dividers.
// The result sits in an output register, so a new request is taken while
// the last result waits for rsp_ch.ready; a stalled receiver holds back
// the next result and, while that waits, new requests. Reset clears the
// sequencer and the output valid.
// ----------------------------------------------------------------------------
module rational_arith_unit
   import rau_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rau_req_if.sink    req_ch,
   rau_rsp_if.source  rsp_ch
);
   localparam int W  = WORD_BITS;
   localparam int PW = 2 * WORD_BITS;

   state_type         state_ff, state_in;
   logic              go_ff, go_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic              an_neg_ff, an_neg_in, bn_neg_ff, bn_neg_in;
   logic [W-1:0]      an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [PW-1:0]     p1_ff, p1_in, p2_ff, p2_in;
   logic [PW-1:0]     num_ff, num_in, den_ff, den_in;
   logic              num_neg_ff, num_neg_in;
   status_type        stat_ff, stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_num_ff, rsp_num_in;
   logic [DEN_W-1:0]  rsp_den_ff, rsp_den_in;
   status_type        rsp_stat_ff, rsp_stat_in;

   // Operand decode of the incoming transfer.
   logic [W-1:0] raw_an, raw_ad, raw_bn, raw_bd;
   logic [W-1:0] mag_an, mag_ad, mag_bn, mag_bd;
   logic         unary, accept;

   // Unit connections.
   logic [W-1:0]  mul_a, mul_b;
   logic [PW-1:0] mul_p, g_odd, u_red, v_red, q_num, q_den;
   logic          mul_done, gcd_done, divn_done, divd_done;
   logic          mul_go, gcd_go, div_go;

   // Sum stage and output checks.
   logic          t2_neg, sum_neg, addsub;
   logic [PW-1:0] sum_mag;
   logic          den_big, num_big, out_free;
   logic [W-1:0]  num_word;

   assign raw_an = req_ch.a_num[W-1:0];
   assign raw_ad = req_ch.a_den[W-1:0];
   assign raw_bn = req_ch.b_num[W-1:0];
   assign raw_bd = req_ch.b_den[W-1:0];
   assign mag_an = raw_an[W-1] ? (-raw_an) : raw_an;
   assign mag_ad = raw_ad[W-1] ? (-raw_ad) : raw_ad;
   assign mag_bn = raw_bn[W-1] ? (-raw_bn) : raw_bn;
   assign mag_bd = raw_bd[W-1] ? (-raw_bd) : raw_bd;
   assign unary  = req_ch.kind[2];
   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign addsub = (kind_ff == KIND_ADD) || (kind_ff == KIND_SUB);
   assign mul_go = go_ff && ((state_ff == ST_MUL1) || (state_ff == ST_MUL2)
                             || (state_ff == ST_MUL3));
   assign gcd_go = go_ff && (state_ff == ST_GCD);
   assign div_go = go_ff && (state_ff == ST_DIV);

   // Multiplier operands for each cross product.
   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      case (state_ff)
         ST_MUL1: begin
            mul_a = an_ff;
            mul_b = (kind_ff == KIND_MUL) ? bn_ff : bd_ff;
         end
         ST_MUL2: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         ST_MUL3: begin
            mul_a = ad_ff;
            mul_b = (kind_ff == KIND_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   // Signed sum of the two cross products, the single product, or the numerator of a unary operation.
   always_comb begin
      t2_neg  = (kind_ff == KIND_SUB) ? !bn_neg_ff : bn_neg_ff;
      sum_neg = an_neg_ff;
      sum_mag = p1_ff;
      if (addsub) begin
         if (an_neg_ff == t2_neg) begin
            sum_mag = p1_ff + p2_ff;
         end else if (p1_ff >= p2_ff) begin
            sum_mag = p1_ff - p2_ff;
         end else begin
            sum_neg = t2_neg;
            sum_mag = p2_ff - p1_ff;
         end
      end else if (kind_ff[2]) begin
         sum_mag = PW'(an_ff);
      end else begin
         sum_neg = an_neg_ff ^ bn_neg_ff;
      end
   end

   // Range checks of the reduced result.
   assign den_big  = |den_ff[PW-1:W-1];
   assign num_big  = num_neg_ff
                   ? ((|num_ff[PW-1:W]) || (num_ff[W-1] && (|num_ff[W-2:0])))
                   : (|num_ff[PW-1:W-1]);
   assign num_word = num_neg_ff ? (-num_ff[W-1:0]) : num_ff[W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer: next state and register loads.
   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      kind_in      = kind_ff;
      an_neg_in    = an_neg_ff;
      bn_neg_in    = bn_neg_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      num_in       = num_ff;
      num_neg_in   = num_neg_ff;
      den_in       = den_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_stat_in  = rsp_stat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in   = req_ch.kind;
               an_in     = mag_an;
               ad_in     = mag_ad;
               bn_in     = mag_bn;
               bd_in     = mag_bd;
               an_neg_in = raw_an[W-1] ^ raw_ad[W-1];
               bn_neg_in = raw_bn[W-1] ^ raw_bd[W-1];
               den_in    = PW'(mag_ad);
               if ((mag_ad == '0) || (!unary && (mag_bd == '0))) begin
                  stat_in  = STAT_ZDEN;
                  state_in = ST_OUT;
               end else if ((req_ch.kind == KIND_DIV) && (mag_bn == '0)) begin
                  stat_in  = STAT_DIVZ;
                  state_in = ST_OUT;
               end else if (unary) begin
                  stat_in  = STAT_OK;
                  state_in = ST_SUM;
               end else begin
                  stat_in  = STAT_OK;
                  state_in = ST_MUL1;
                  go_in    = 1'b1;
               end
            end
         end
         ST_MUL1: begin
            if (mul_done) begin
               p1_in    = mul_p;
               state_in = addsub ? ST_MUL2 : ST_MUL3;
               go_in    = 1'b1;
            end
         end
         ST_MUL2: begin
            if (mul_done) begin
               p2_in    = mul_p;
               state_in = ST_MUL3;
               go_in    = 1'b1;
            end
         end
         ST_MUL3: begin
            if (mul_done) begin
               den_in   = mul_p;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sum_mag == '0) begin
               num_in     = '0;
               num_neg_in = 1'b0;
               den_in     = PW'(1);
               state_in   = ST_OUT;
            end else begin
               num_in     = sum_mag;
               num_neg_in = sum_neg;
               state_in   = ST_GCD;
               go_in      = 1'b1;
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               state_in = ST_DIV;
               go_in    = 1'b1;
            end
         end
         ST_DIV: begin
            if (divn_done) begin
               num_in   = q_num;
               den_in   = q_den;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (stat_ff != STAT_OK) begin
                  rsp_num_in  = '0;
                  rsp_den_in  = '0;
                  rsp_stat_in = stat_ff;
               end else if (den_big || num_big) begin
                  rsp_num_in  = '0;
                  rsp_den_in  = '0;
                  rsp_stat_in = STAT_OVF;
               end else begin
                  rsp_num_in  = FIELD_W'($signed(num_word));
                  rsp_den_in  = DEN_W'(den_ff[W-2:0]);
                  rsp_stat_in = STAT_OK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      an_neg_ff  <= an_neg_in;
      bn_neg_ff  <= bn_neg_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      num_ff     <= num_in;
      num_neg_ff <= num_neg_in;
      den_ff     <= den_in;
      stat_ff    <= stat_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_stat_ff <= rsp_stat_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.res_num = rsp_num_ff;
   assign rsp_ch.res_den = rsp_den_ff;
   assign rsp_ch.status  = rsp_stat_ff;

   // Cross-product multiplier.
   rau_mul #(.W(W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   // Odd part of the GCD of numerator and denominator magnitudes.
   rau_gcd #(.PW(PW)) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_go),
      .u_init (num_ff),
      .v_init (den_ff),
      .done   (gcd_done),
      .g_odd  (g_odd),
      .u_red  (u_red),
      .v_red  (v_red)
   );

   // Exact divisions by the odd part of the GCD.
   rau_div #(.PW(PW)) u_div_num (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (u_red),
      .divisor  (g_odd),
      .done     (divn_done),
      .quot     (q_num)
   );

   rau_div #(.PW(PW)) u_div_den (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (v_red),
      .divisor  (g_odd),
      .done     (divd_done),
      .quot     (q_den)
   );

   // At most one of the multiplier, the GCD engine and the divider pair is launched at a time.
   a_one_launch: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_go, gcd_go, div_go}))
      else $error("more than one arithmetic unit launched");

   // Both dividers run in lockstep.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      divn_done == divd_done)
      else $error("divider done pulses out of step");

   // Multiplier results arrive only while a product is awaited.
   a_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL1 || state_ff == ST_MUL2
                    || state_ff == ST_MUL3))
      else $error("multiplier finished outside a product state");

   // A GCD result arrives only in the GCD state.
   a_gcd_state: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> (state_ff == ST_GCD))
      else $error("GCD finished outside its state");

   // A good result always carries a nonzero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_stat_ff == STAT_OK)) |-> (rsp_den_ff != '0))
      else $error("zero denominator with good status");
endmodule
`default_nettype wire

[verif/rau_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic testbench channel notes
// The channel interfaces come from the RTL file rau_if.sv; this file holds
// the shared helper package used by the checker and the stimulus top.
// ----------------------------------------------------------------------------
package rau_tb_pkg;
   import rau_pkg::*;

   // One request as the stimulus top sends it.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] a_num;
      logic [FIELD_W-1:0] a_den;
      logic [FIELD_W-1:0] b_num;
      logic [FIELD_W-1:0] b_den;
   } frac_req_type;

   // One result as the block should return it.
   typedef struct packed {
      logic [FIELD_W-1:0] res_num;
      logic [DEN_W-1:0]   res_den;
      status_type         status;
   } frac_rsp_type;
endpackage

[verif/rau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic result checker
// Watches both channels, computes the reduced fraction for every request
// transfer and compares each response transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rau_checker
   import rau_pkg::*;
   import rau_tb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rau_req_if        req_ch,
   rau_rsp_if        rsp_ch,
   output int        fail_count,
   output int        pending,
   output int        rsp_seen
);
   frac_rsp_type expected_results[$];

   // Greatest common divisor of two nonzero 64-bit magnitudes.
   function automatic logic [63:0] gcd64(logic [63:0] u, logic [63:0] v);
      logic [63:0] t;
      while (v != 0) begin
         t = u % v;
         u = v;
         v = t;
      end
      return u;
   endfunction

   // Exact reduced result of one request at 32-bit words.
   function automatic frac_rsp_type reduce_fraction(frac_req_type r);
      frac_rsp_type res;
      logic        an_s, ad_s, bn_s, bd_s, n_s, t1_s, t2_s;
      logic [63:0] an, ad, bn, bd, n, d, t1, t2, g;
      logic        unary;
      res = '{res_num: '0, res_den: '0, status: STAT_OK};
      unary = (r.kind > KIND_DIV);
      an_s = r.a_num[31]; an = an_s ? 64'(-$signed({1'b1, r.a_num})) : 64'(r.a_num);
      ad_s = r.a_den[31]; ad = ad_s ? 64'(-$signed({1'b1, r.a_den})) : 64'(r.a_den);
      bn_s = r.b_num[31]; bn = bn_s ? 64'(-$signed({1'b1, r.b_num})) : 64'(r.b_num);
      bd_s = r.b_den[31]; bd = bd_s ? 64'(-$signed({1'b1, r.b_den})) : 64'(r.b_den);
      if (ad == 0 || (!unary && bd == 0)) begin
         res.status = STAT_ZDEN;
         return res;
      end
      if (r.kind == KIND_DIV && bn == 0) begin
         res.status = STAT_DIVZ;
         return res;
      end
      // Move the denominator signs into the numerators.
      an_s = an_s ^ ad_s;
      bn_s = bn_s ^ bd_s;
      case (r.kind)
         KIND_ADD, KIND_SUB: begin
            t1_s = an_s;
            t1 = an * bd;
            t2_s = (r.kind == KIND_SUB) ? !bn_s : bn_s;
            t2 = bn * ad;
            if (t1_s == t2_s) begin
               n_s = t1_s; n = t1 + t2;
            end else if (t1 >= t2) begin
               n_s = t1_s; n = t1 - t2;
            end else begin
               n_s = t2_s; n = t2 - t1;
            end
            d = ad * bd;
         end
         KIND_MUL: begin
            n_s = an_s ^ bn_s; n = an * bn; d = ad * bd;
         end
         KIND_DIV: begin
            n_s = an_s ^ bn_s; n = an * bd; d = ad * bn;
         end
         default: begin
            n_s = an_s; n = an; d = ad;
         end
      endcase
      if (n == 0) begin
         n_s = 1'b0;
         d = 1;
      end else begin
         g = gcd64(n, d);
         n = n / g;
         d = d / g;
      end
      if (d > 64'h7fff_ffff || n > (n_s ? 64'h8000_0000 : 64'h7fff_ffff)) begin
         res.status = STAT_OVF;
         return res;
      end
      res.res_num = n_s ? 32'(-n) : 32'(n);
      res.res_den = 31'(d);
      return res;
   endfunction

   // Predict on request transfers, compare on response transfers.
   always @(posedge clock) begin
      frac_req_type item;
      frac_rsp_type want;
      if (reset) begin
         fail_count <= 0;
         rsp_seen <= 0;
         pending <= 0;
         expected_results.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            item = '{kind: req_ch.kind, a_num: req_ch.a_num, a_den: req_ch.a_den,
                     b_num: req_ch.b_num, b_den: req_ch.b_den};
            expected_results.push_back(reduce_fraction(item));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %0d/%0d status %0d", $time,
                        rsp_ch.res_num, rsp_ch.res_den, rsp_ch.status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.res_num !== want.res_num || rsp_ch.res_den !== want.res_den ||
                   rsp_ch.status !== want.status) begin
                  $display("%0t: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                           $time, $signed(want.res_num), want.res_den, want.status,
                           rsp_ch.res_num, rsp_ch.res_den, rsp_ch.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_results.size();
      end
   end
endmodule

[verif/rational_arith_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends directed corner cases and then random fraction operations in
// bursts, with a stalling receiver; a checker module scores every result.
// ----------------------------------------------------------------------------
module rational_arith_unit_tb;
   import rau_pkg::*;
   import rau_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1350;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, rsp_seen;
   int   sent_count = 0;
   int   burst_left = 0;

   rau_req_if req_ch ();
   rau_rsp_if rsp_ch ();

   rational_arith_unit dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   rau_checker result_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver stalls: long free runs alternate with random stall patterns.
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      int mode;
      mode = (rsp_seen / 100) % 3;
      if (mode == 0) rsp_ch.ready <= 1'b1;
      else if (mode == 1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else rsp_ch.ready <= ($urandom_range(0, 7) == 0);
   end

   // Pick an operand value that leans toward the extremes and small values.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3, 4: return 32'($signed($urandom_range(0, 2000)) - 1000);
         5: return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
         6: return 32'($signed($urandom_range(0, 65535)) - 32768);
         default: return $urandom;
      endcase
   endfunction

   // Drive one request, after an idle gap at the start of a burst, and hold it until it transfers.
   task automatic send_request(frac_req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= r.kind;
      req_ch.a_num <= r.a_num;
      req_ch.a_den <= r.a_den;
      req_ch.b_num <= r.b_num;
      req_ch.b_den <= r.b_den;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      sent_count++;
   endtask

   // Stimulus: directed corners, then random operations.
   initial begin
      frac_req_type r;
      frac_req_type directed[$];
      int wait_cycles;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_ADD;
      req_ch.a_num = '0; req_ch.a_den = 32'd1;
      req_ch.b_num = '0; req_ch.b_den = 32'd1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed = '{
         '{KIND_ADD,  32'd1,          32'd2,          32'd1,          32'd3},
         '{KIND_SUB,  32'd1,          32'd2,          32'd1,          32'd2},
         '{KIND_MUL,  32'h8000_0000,  32'd1,          32'h8000_0000,  32'd1},
         '{KIND_DIV,  32'd3,          32'hffff_fffb,  32'd7,          32'd9},
         '{KIND_NORM, 32'd6,          32'hffff_fffc,  32'd0,          32'd0},
         '{KIND_NORM, 32'hffff_ffff,  32'h8000_0000,  32'd5,          32'd5},
         '{KIND_NORM, 32'h8000_0000,  32'hffff_ffff,  32'd1,          32'd1},
         '{KIND_NORM, 32'h8000_0000,  32'd1,          32'd1,          32'd1},
         '{KIND_ADD,  32'd1,          32'd0,          32'd1,          32'd1},
         '{KIND_ADD,  32'd1,          32'd1,          32'd1,          32'd0},
         '{KIND_NORM, 32'd1,          32'd0,          32'd1,          32'd1},
         '{KIND_NORM, 32'd7,          32'd3,          32'd1,          32'd0},
         '{KIND_DIV,  32'd1,          32'd2,          32'd0,          32'd5},
         '{KIND_SUB,  32'd5,          32'd7,          32'd5,          32'd7},
         '{KIND_MUL,  32'd0,          32'h8000_0000,  32'd9,          32'd4},
         '{KIND_ADD,  32'h7fff_ffff,  32'd1,          32'h7fff_ffff,  32'd1},
         '{KIND_SUB,  32'h8000_0000,  32'hffff_ffff,  32'h7fff_ffff,  32'h7fff_fffe},
         '{KIND_DIV,  32'h7fff_ffff,  32'h8000_0000,  32'h8000_0000,  32'h7fff_ffff},
         '{3'd5,      32'd10,         32'd4,          32'd0,          32'd0},
         '{3'd6,      32'hffff_fff6,  32'hffff_fffc,  32'd1,          32'd1},
         '{3'd7,      32'hffff_ffff,  32'hffff_ffff,  32'hffff_ffff,  32'hffff_ffff},
         '{KIND_MUL,  32'hffff_ffff,  32'hffff_ffff,  32'hffff_ffff,  32'hffff_ffff}
      };
      foreach (directed[i]) send_request(directed[i]);

      // Random part: mostly valid operands, some zero denominators.
      repeat (RANDOM_ITEMS) begin
         r.kind  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
         r.a_num = pick_word();
         r.a_den = pick_word();
         r.b_num = pick_word();
         r.b_den = pick_word();
         if (r.a_den == 0 && $urandom_range(0, 3) != 0) r.a_den = 32'd1;
         if (r.b_den == 0 && $urandom_range(0, 3) != 0) r.b_den = 32'd1;
         send_request(r);
      end
      req_ch.valid <= 1'b0;

      // Drain, then keep watching for any stray result.
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (700) @(posedge clock);
      $display("Sent %0d fraction requests over all operations and error cases;", sent_count);
      $display("checked %0d results under bursty input and stalled output.", rsp_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Timeout guard.
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end
endmodule

[rational_arith_unit.f]
sv/rau_pkg.sv
sv/rau_if.sv
sv/rau_mul.sv
sv/rau_gcd.sv
sv/rau_div.sv
sv/rational_arith_unit.sv
verif/rau_tb_if.sv
verif/rau_checker.sv
verif/rational_arith_unit_tb.sv
